// ===== src/llgc_pkg.sv =====
// Shared types, widths and codes for the laser line gap closer.
package llgc_pkg;

	localparam int LINE_LEN_DEF = 1024;
	localparam int LINE_LEN_MAX = 8192;
	localparam int FIFO_DEPTH   = 4;

	localparam int POS_W = 14;
	localparam int H_W   = 16;
	localparam int R_W   = 8;
	localparam int IDX_W = 10;
	localparam int CFG_W = 11;
	localparam int REG_W = 2;

	localparam logic [CFG_W-1:0] GAP_X_RST   = 11'd10;
	localparam logic [CFG_W-1:0] GAP_Y_RST   = 11'd10;
	localparam logic [CFG_W-1:0] CLOSURE_RST = 11'd10;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	typedef enum logic [REG_W-1:0] {
		REG_GAP_X   = 2'd0,
		REG_GAP_Y   = 2'd1,
		REG_CLOSURE = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		OP_CLEAR,
		OP_SNIP,
		OP_READ
	} op_kind_t;

	typedef struct packed {
		logic                    command;
		logic signed [H_W-1:0]   sample_height;
		logic        [R_W-1:0]   sample_rank;
		logic                    last_sample;
		logic        [IDX_W-1:0] read_index;
	} req_t;

	typedef struct packed {
		logic signed [H_W-1:0] out_height;
		logic        [R_W-1:0] out_rank;
		logic                  in_line;
	} rsp_t;

	typedef struct packed {
		logic [REG_W-1:0] index;
		logic [CFG_W-1:0] value;
	} cfg_t;

	typedef struct packed {
		logic [CFG_W-1:0] gap_x;
		logic [CFG_W-1:0] gap_y;
		logic [CFG_W-1:0] closure;
	} cfg_regs_t;

	typedef struct packed {
		op_kind_t         kind;
		logic [POS_W-1:0] a;
		logic [POS_W-1:0] b;
		logic             in_line;
	} op_t;

endpackage

// ===== src/llgc_chan_if.sv =====
// Valid/ready channel carrying one payload type.
interface llgc_chan_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== src/llgc_fifo.sv =====
// Short operation queue between the front and back parts.
module llgc_fifo #(
	parameter int DEPTH = llgc_pkg::FIFO_DEPTH
) (
	input logic         clk,
	input logic         arst_n,
	llgc_chan_if.sink   push,
	llgc_chan_if.source pop
);
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	llgc_pkg::op_t   slot_q [DEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign push.ready = (cnt_q != CW'(DEPTH));
	assign pop.valid  = (cnt_q != '0);
	assign pop.data   = slot_q[rd_q];
	assign do_push    = push.valid && push.ready;
	assign do_pop     = pop.valid && pop.ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (!do_push && do_pop) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end
endmodule

// ===== src/llgc_front.sv =====
// Front part: loads samples, finds valid span, cuts snippets and queues operations.
module llgc_front #(
	parameter int LINE_LEN = llgc_pkg::LINE_LEN_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	llgc_chan_if.sink                             req,
	llgc_chan_if.source                           op,
	input  logic        [llgc_pkg::CFG_W-1:0]     gap_y,
	input  logic                                  back_idle,
	input  logic        [$clog2(LINE_LEN)-1:0]    rdb_addr,
	output logic signed [llgc_pkg::H_W-1:0]       rdb_height,
	output logic        [llgc_pkg::R_W-1:0]       rdb_rank
);
	localparam int AW     = $clog2(LINE_LEN);
	localparam int CW     = $clog2(LINE_LEN + 1);
	localparam int H_W    = llgc_pkg::H_W;
	localparam int R_W    = llgc_pkg::R_W;
	localparam int DIFF_W = H_W + 1;

	typedef enum logic [3:0] {
		F_IDLE, F_CLR, F_FIND, F_SCAN0, F_SCAN1, F_RD, F_EV, F_TAIL, F_DRAIN
	} state_t;

	logic signed [H_W-1:0] h_mem [LINE_LEN];
	logic        [R_W-1:0] r_mem [LINE_LEN];

	state_t                state_q;
	logic [CW-1:0]         len_q;
	logic                  done_q;
	logic [CW-1:0]         cnt_q;
	logic                  pend_s1;
	logic [CW-1:0]         idx_s1;
	logic                  found_q;
	logic [CW-1:0]         first_q;
	logic [CW-1:0]         last_q;
	logic [CW-1:0]         x_q;
	logic [CW-1:0]         start_q;
	logic                  open_q;
	logic signed [H_W-1:0] prev_h_q;
	logic signed [H_W-1:0] rda_h_q;
	logic [R_W-1:0]        rda_r_q;
	logic signed [H_W-1:0] rdb_h_q;
	logic [R_W-1:0]        rdb_r_q;

	logic [AW-1:0]         rda_addr;
	logic [CW-1:0]         len_eff;
	logic [CW-1:0]         x_next;
	logic                  accept;
	logic                  accept_w;
	logic                  mem_we;
	logic signed [DIFF_W-1:0] diff;
	logic [DIFF_W-1:0]     adiff;
	logic                  jump;
	logic                  bad;
	logic                  cut;
	logic                  open_nx;

	assign rdb_height = rdb_h_q;
	assign rdb_rank   = rdb_r_q;

	assign len_eff  = done_q ? '0 : len_q;
	assign x_next   = x_q + CW'(1);
	assign accept   = req.valid && req.ready;
	assign accept_w = accept && (req.data.command == llgc_pkg::CMD_WRITE);
	assign mem_we   = accept_w && (len_eff < CW'(LINE_LEN));
	assign req.ready = (state_q == F_IDLE) && op.ready;

	assign diff  = {prev_h_q[H_W-1], prev_h_q} - {rda_h_q[H_W-1], rda_h_q};
	assign adiff = diff[H_W] ? DIFF_W'(-diff) : DIFF_W'(diff);
	assign jump  = adiff > DIFF_W'({gap_y, 4'b0000});
	assign bad   = (rda_r_q == '0);
	assign cut   = open_q && (jump || bad);
	assign open_nx = open_q && !cut;

	always_comb begin
		unique case (state_q)
			F_FIND:       rda_addr = cnt_q[AW-1:0];
			F_SCAN0:      rda_addr = first_q[AW-1:0];
			F_RD, F_EV:   rda_addr = x_next[AW-1:0];
			default:      rda_addr = '0;
		endcase
	end

	always_comb begin
		op.valid = 1'b0;
		op.data  = '0;
		unique case (state_q)
			F_IDLE: begin
				op.valid        = req.valid && (req.data.command == llgc_pkg::CMD_READ);
				op.data.kind    = llgc_pkg::OP_READ;
				op.data.a       = llgc_pkg::POS_W'(req.data.read_index);
				op.data.in_line = (CW'(req.data.read_index) < len_q);
			end
			F_CLR: begin
				op.valid     = 1'b1;
				op.data.kind = llgc_pkg::OP_CLEAR;
			end
			F_EV: begin
				op.valid     = cut;
				op.data.kind = llgc_pkg::OP_SNIP;
				op.data.a    = llgc_pkg::POS_W'(start_q);
				op.data.b    = llgc_pkg::POS_W'(x_next);
			end
			F_TAIL: begin
				op.valid     = open_q;
				op.data.kind = llgc_pkg::OP_SNIP;
				op.data.a    = llgc_pkg::POS_W'(start_q);
				op.data.b    = llgc_pkg::POS_W'(last_q + CW'(1));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			h_mem[len_eff[AW-1:0]] <= req.data.sample_height;
			r_mem[len_eff[AW-1:0]] <= req.data.sample_rank;
		end
		rda_h_q <= h_mem[rda_addr];
		rda_r_q <= r_mem[rda_addr];
		rdb_h_q <= h_mem[rdb_addr];
		rdb_r_q <= r_mem[rdb_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= F_DRAIN;
			len_q    <= '0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
			pend_s1  <= 1'b0;
			idx_s1   <= '0;
			found_q  <= 1'b0;
			first_q  <= '0;
			last_q   <= '0;
			x_q      <= '0;
			start_q  <= '0;
			open_q   <= 1'b0;
			prev_h_q <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept_w) begin
						len_q  <= mem_we ? len_eff + CW'(1) : len_eff;
						done_q <= 1'b0;
						if (req.data.last_sample) begin
							done_q  <= 1'b1;
							state_q <= F_CLR;
						end
					end
				end
				F_CLR: begin
					if (op.ready) begin
						cnt_q   <= '0;
						pend_s1 <= 1'b0;
						found_q <= 1'b0;
						state_q <= F_FIND;
					end
				end
				F_FIND: begin
					if (cnt_q != len_q) begin
						cnt_q   <= cnt_q + CW'(1);
						idx_s1  <= cnt_q;
						pend_s1 <= 1'b1;
					end else begin
						pend_s1 <= 1'b0;
					end
					if (pend_s1 && (rda_r_q != '0)) begin
						if (!found_q) begin
							first_q <= idx_s1;
						end
						found_q <= 1'b1;
						last_q  <= idx_s1;
					end
					if ((cnt_q == len_q) && !pend_s1) begin
						state_q <= found_q ? F_SCAN0 : F_DRAIN;
					end
				end
				F_SCAN0: begin
					state_q <= F_SCAN1;
				end
				F_SCAN1: begin
					prev_h_q <= rda_h_q;
					x_q      <= first_q;
					start_q  <= first_q;
					open_q   <= 1'b1;
					state_q  <= F_RD;
				end
				F_RD: begin
					state_q <= (x_q == last_q) ? F_TAIL : F_EV;
				end
				F_EV: begin
					if (!cut || op.ready) begin
						if (!open_nx && jump && !bad) begin
							start_q <= x_next;
							open_q  <= 1'b1;
						end else begin
							open_q  <= open_nx;
						end
						prev_h_q <= rda_h_q;
						x_q      <= x_next;
						state_q  <= F_RD;
					end
				end
				F_TAIL: begin
					if (!open_q || op.ready) begin
						state_q <= F_DRAIN;
					end
				end
				F_DRAIN: begin
					if (back_idle) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_DRAIN;
			endcase
		end
	end
endmodule

// ===== src/llgc_back.sv =====
// Back part: clears, copies and interpolates the output line and serves reads.
module llgc_back #(
	parameter int LINE_LEN = llgc_pkg::LINE_LEN_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	llgc_chan_if.sink                          op,
	llgc_chan_if.source                        rsp,
	input  logic        [llgc_pkg::CFG_W-1:0]  gap_x,
	input  logic        [llgc_pkg::CFG_W-1:0]  closure,
	output logic        [$clog2(LINE_LEN)-1:0] rdb_addr,
	input  logic signed [llgc_pkg::H_W-1:0]    rdb_height,
	input  logic        [llgc_pkg::R_W-1:0]    rdb_rank,
	output logic                               idle
);
	localparam int AW  = $clog2(LINE_LEN);
	localparam int CW  = $clog2(LINE_LEN + 1);
	localparam int DW  = CW + 4;
	localparam int WW  = llgc_pkg::POS_W + 1;
	localparam int H_W = llgc_pkg::H_W;
	localparam int R_W = llgc_pkg::R_W;
	localparam int SW  = $clog2(H_W);

	typedef enum logic [3:0] {
		B_CLR, B_IDLE, B_RD1, B_RD2, B_SNIP, B_COPY, B_IA, B_IB, B_IC, B_DIV, B_LOOP
	} state_t;

	logic signed [H_W-1:0] oh_mem [LINE_LEN];
	logic        [R_W-1:0] or_mem [LINE_LEN];

	state_t                st_q;
	logic [CW-1:0]         cnt_q;
	logic [CW-1:0]         pke_q;
	logic [CW-1:0]         s_q;
	logic [CW-1:0]         e_q;
	logic [CW-1:0]         a_q;
	logic [CW-1:0]         gap_q;
	logic [CW-1:0]         x_q;
	logic                  cp_s1;
	logic [AW-1:0]         cpa_s1;
	logic [llgc_pkg::POS_W-1:0] idx_q;
	logic                  in_line_q;
	logic                  rd_ok_q;
	logic signed [H_W-1:0] y0_q;
	logic [R_W-1:0]        ra_q;
	logic [R_W-1:0]        rank_q;
	logic                  neg_q;
	logic [DW-1:0]         den_q;
	logic [H_W-1:0]        dvd_q;
	logic [DW-1:0]         rem_q;
	logic [SW-1:0]         dcnt_q;
	logic [H_W-1:0]        q_q;
	logic [DW-1:0]         r_q;
	logic signed [H_W-1:0] ord_h_q;
	logic [R_W-1:0]        ord_r_q;
	logic                  rsp_v_q;
	llgc_pkg::rsp_t        rsp_d_q;

	logic                  ow_en;
	logic [AW-1:0]         ow_addr;
	logic signed [H_W-1:0] ow_h;
	logic [R_W-1:0]        ow_r;
	logic [CW-1:0]         gap_c;
	logic [CW-1:0]         ax;
	logic                  do_interp;
	logic [DW:0]           rem_n;
	logic                  qbit;
	logic [DW:0]           rem_s;
	logic [DW:0]           r2;
	logic                  wrap;
	logic [DW:0]           r2_s;
	logic [H_W-1:0]        ofs;
	logic signed [H_W:0]   jmp;
	logic [R_W-1:0]        rmin;
	logic                  rsp_load;

	assign idle      = (st_q == B_IDLE);
	assign op.ready  = (st_q == B_IDLE);
	assign rsp.valid = rsp_v_q;
	assign rsp.data  = rsp_d_q;
	assign rsp_load  = (st_q == B_RD2) && (!rsp_v_q || rsp.ready);

	assign gap_c     = s_q - pke_q + CW'(1);
	assign do_interp = (pke_q != '0) && (gap_c > CW'(1)) && (WW'(gap_c) <= WW'(closure));
	assign ax        = a_q + x_q;

	assign rem_n = {rem_q, dvd_q[H_W-1]};
	assign qbit  = rem_n >= {1'b0, den_q};
	assign rem_s = qbit ? rem_n - {1'b0, den_q} : rem_n;

	assign r2   = {1'b0, r_q} + {1'b0, rem_q};
	assign wrap = r2 >= {1'b0, den_q};
	assign r2_s = wrap ? r2 - {1'b0, den_q} : r2;
	assign ofs  = {q_q[H_W-5:0], 4'b0000};

	assign jmp  = {rdb_height[H_W-1], rdb_height} - {y0_q[H_W-1], y0_q};
	assign rmin = (ra_q < rdb_rank) ? ra_q : rdb_rank;

	always_comb begin
		unique case (st_q)
			B_COPY:  rdb_addr = cnt_q[AW-1:0];
			B_IA:    rdb_addr = a_q[AW-1:0];
			B_IB:    rdb_addr = s_q[AW-1:0];
			default: rdb_addr = '0;
		endcase
	end

	always_comb begin
		ow_en   = 1'b0;
		ow_addr = '0;
		ow_h    = '0;
		ow_r    = '0;
		unique case (st_q)
			B_CLR: begin
				ow_en   = 1'b1;
				ow_addr = cnt_q[AW-1:0];
			end
			B_COPY: begin
				ow_en   = cp_s1;
				ow_addr = cpa_s1;
				ow_h    = rdb_height;
				ow_r    = rdb_rank;
			end
			B_LOOP: begin
				ow_en   = 1'b1;
				ow_addr = ax[AW-1:0];
				ow_h    = neg_q ? y0_q - ofs : y0_q + ofs;
				ow_r    = rank_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ow_en) begin
			oh_mem[ow_addr] <= ow_h;
			or_mem[ow_addr] <= ow_r;
		end
		if (st_q == B_RD1) begin
			ord_h_q <= oh_mem[idx_q[AW-1:0]];
			ord_r_q <= or_mem[idx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= B_CLR;
			cnt_q     <= '0;
			pke_q     <= '0;
			s_q       <= '0;
			e_q       <= '0;
			a_q       <= '0;
			gap_q     <= '0;
			x_q       <= '0;
			cp_s1     <= 1'b0;
			cpa_s1    <= '0;
			idx_q     <= '0;
			in_line_q <= 1'b0;
			rd_ok_q   <= 1'b0;
			y0_q      <= '0;
			ra_q      <= '0;
			rank_q    <= '0;
			neg_q     <= 1'b0;
			den_q     <= '0;
			dvd_q     <= '0;
			rem_q     <= '0;
			dcnt_q    <= '0;
			q_q       <= '0;
			r_q       <= '0;
			rsp_v_q   <= 1'b0;
			rsp_d_q   <= '0;
		end else begin
			if (rsp_load) begin
				rsp_v_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				rsp_v_q <= 1'b0;
			end
			unique case (st_q)
				B_CLR: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(LINE_LEN - 1)) begin
						st_q <= B_IDLE;
					end
				end
				B_IDLE: begin
					if (op.valid) begin
						unique case (op.data.kind)
							llgc_pkg::OP_CLEAR: begin
								cnt_q <= '0;
								pke_q <= '0;
								st_q  <= B_CLR;
							end
							llgc_pkg::OP_READ: begin
								idx_q     <= op.data.a;
								in_line_q <= op.data.in_line;
								st_q      <= B_RD1;
							end
							llgc_pkg::OP_SNIP: begin
								s_q  <= CW'(op.data.a);
								e_q  <= CW'(op.data.b);
								st_q <= B_SNIP;
							end
							default: ;
						endcase
					end
				end
				B_RD1: begin
					rd_ok_q <= (idx_q < llgc_pkg::POS_W'(LINE_LEN));
					st_q    <= B_RD2;
				end
				B_RD2: begin
					if (rsp_load) begin
						rsp_d_q.out_height <= rd_ok_q ? ord_h_q : '0;
						rsp_d_q.out_rank   <= rd_ok_q ? ord_r_q : '0;
						rsp_d_q.in_line    <= in_line_q;
						st_q               <= B_IDLE;
					end
				end
				B_SNIP: begin
					cp_s1 <= 1'b0;
					cnt_q <= s_q;
					st_q  <= (WW'(e_q - s_q) > WW'(gap_x)) ? B_COPY : B_IDLE;
				end
				B_COPY: begin
					if (cnt_q != e_q) begin
						cnt_q  <= cnt_q + CW'(1);
						cpa_s1 <= cnt_q[AW-1:0];
						cp_s1  <= 1'b1;
					end else begin
						cp_s1 <= 1'b0;
						if (!cp_s1) begin
							if (do_interp) begin
								a_q   <= pke_q - CW'(1);
								gap_q <= gap_c;
								st_q  <= B_IA;
							end else begin
								pke_q <= e_q;
								st_q  <= B_IDLE;
							end
						end
					end
				end
				B_IA: begin
					st_q <= B_IB;
				end
				B_IB: begin
					y0_q <= rdb_height;
					ra_q <= rdb_rank;
					st_q <= B_IC;
				end
				B_IC: begin
					neg_q  <= jmp[H_W];
					dvd_q  <= jmp[H_W] ? H_W'(-jmp) : H_W'(jmp);
					rank_q <= rmin >> 1;
					den_q  <= {gap_q, 4'b0000};
					rem_q  <= '0;
					dcnt_q <= '0;
					st_q   <= B_DIV;
				end
				B_DIV: begin
					rem_q  <= rem_s[DW-1:0];
					dvd_q  <= {dvd_q[H_W-2:0], qbit};
					dcnt_q <= dcnt_q + SW'(1);
					if (dcnt_q == SW'(H_W - 1)) begin
						x_q  <= '0;
						q_q  <= '0;
						r_q  <= '0;
						st_q <= B_LOOP;
					end
				end
				B_LOOP: begin
					r_q <= r2_s[DW-1:0];
					q_q <= q_q + dvd_q + H_W'(wrap);
					x_q <= x_q + CW'(1);
					if (x_q == gap_q) begin
						pke_q <= e_q;
						st_q  <= B_IDLE;
					end
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end
endmodule

// ===== src/laser_line_gap_closer.sv =====
// Top level of the laser line gap closer.
//
// channel  modport  payload                                          transaction
// req      sink     command, sample_height, sample_rank,             write a sample or
//                   last_sample, read_index                          request a read
// rsp      source   out_height, out_rank, in_line                    one per read
// cfg      sink     index, value                                     register write
//
// Samples load one per cycle while the operation queue has room; reads wait in that queue and
// the back part serves them one at a time. Processing after last_sample: output clear, span
// search, a pass over the spanned samples, a copy per kept snippet, interpolation per closed gap.
// Reset runs a clearing pass of the output memory; req.ready stays low meanwhile.
// While a line is processed req.ready is low; a stalled rsp holds the back part in its
// read state, and req.ready drops once the operation queue is full.
module laser_line_gap_closer #(
	parameter int LINE_LEN   = llgc_pkg::LINE_LEN_DEF,
	parameter int FIFO_DEPTH = llgc_pkg::FIFO_DEPTH
) (
	input logic         clk,
	input logic         arst_n,
	llgc_chan_if.sink   req,
	llgc_chan_if.source rsp,
	llgc_chan_if.sink   cfg
);
	localparam int AW = $clog2(LINE_LEN);

	llgc_chan_if #(.T(llgc_pkg::op_t)) op_in ();
	llgc_chan_if #(.T(llgc_pkg::op_t)) op_out ();

	llgc_pkg::cfg_regs_t       cfg_q;
	logic                      back_idle;
	logic                      drained;
	logic [AW-1:0]             rdb_addr;
	logic signed [llgc_pkg::H_W-1:0] rdb_height;
	logic [llgc_pkg::R_W-1:0]  rdb_rank;

	assign cfg.ready = 1'b1;
	assign drained   = back_idle && !op_out.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gap_x   <= llgc_pkg::GAP_X_RST;
			cfg_q.gap_y   <= llgc_pkg::GAP_Y_RST;
			cfg_q.closure <= llgc_pkg::CLOSURE_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.data.index)
				llgc_pkg::REG_GAP_X:   cfg_q.gap_x   <= cfg.data.value;
				llgc_pkg::REG_GAP_Y:   cfg_q.gap_y   <= cfg.data.value;
				llgc_pkg::REG_CLOSURE: cfg_q.closure <= cfg.data.value;
				default: ;
			endcase
		end
	end

	llgc_front #(.LINE_LEN(LINE_LEN)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.op         (op_in),
		.gap_y      (cfg_q.gap_y),
		.back_idle  (drained),
		.rdb_addr   (rdb_addr),
		.rdb_height (rdb_height),
		.rdb_rank   (rdb_rank)
	);

	llgc_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (op_in),
		.pop    (op_out)
	);

	llgc_back #(.LINE_LEN(LINE_LEN)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (op_out),
		.rsp        (rsp),
		.gap_x      (cfg_q.gap_x),
		.closure    (cfg_q.closure),
		.rdb_addr   (rdb_addr),
		.rdb_height (rdb_height),
		.rdb_rank   (rdb_rank),
		.idle       (back_idle)
	);
endmodule

// ===== src/llgc_check.sv =====
// Port checker for the laser line gap closer, bound to the top level.
module llgc_check (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input logic           req_command,
	input logic           req_last,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input llgc_pkg::rsp_t rsp_data
);
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result withdrawn while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_data))
		else $error("result changed while stalled");

	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_command == llgc_pkg::CMD_WRITE) && req_last
		|=> !req_ready)
		else $error("input taken while line processing starts");

	a_reset_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !req_ready)
		else $error("input taken during clearing pass");
endmodule

bind laser_line_gap_closer llgc_check u_llgc_check (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.req_command (req.data.command),
	.req_last    (req.data.last_sample),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_data    (rsp.data)
);
